// ----- rtl/core/oaht_pkg.sv -----
package oaht_pkg;

  localparam int HashMult = 32'h9E3779B1;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    MARK_EMPTY    = 2'd0,
    MARK_OCCUPIED = 2'd1,
    MARK_DELETED  = 2'd2,
    MARK_SPARE    = 2'd3
  } mark_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request word
    logic hash;      // register product
    logic div_start; // start remainder unit
    logic home;      // set probe index from remainder
    logic rd;        // issue memory read at probe index
    logic eval;      // evaluate read data, advance index
    logic commit;    // perform write and register result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clearing;  // slot marks being cleared after reset
    logic div_done;
    logic stop;      // probe hit an empty slot or the key
    logic exhausted; // probe count reached capacity
  } dp_sts_t;

endpackage

// ----- rtl/core/oaht_div.sv -----
module oaht_div
  import oaht_pkg::*;
#(
  parameter int NW = 32,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW+1:0] trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r, q_r[NW-1]} - {2'b00, den_r};
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt = {q_r[NW-2:0], 1'b0};
      if (!trial[DW+1]) rem_nxt = trial[DW:0];
      else rem_nxt = {rem_r[DW-1:0], q_r[NW-1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign rem = rem_r[DW-1:0];

endmodule

// ----- rtl/core/oaht_dp.sv -----
module oaht_dp
  import oaht_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WIDTH = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                cmd,
  output dp_sts_t                sts,
  input  logic [10:0]            cap_reg,
  input  logic [1:0]             in_req_type,
  input  logic [KEY_WIDTH-1:0]   in_key,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_found,
  output logic [31:0]            out_value_out,
  output logic                   out_inserted_new,
  output logic                   out_table_full,
  output logic [10:0]            out_entry_total
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int DW = (CW > 11) ? CW : 11;

  logic [1:0]             mark_mem [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0]   key_mem  [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] val_mem  [TABLE_DEPTH];

  logic                   clr_r;
  logic [AW-1:0]          clr_idx_r;
  logic                   mark_we;
  logic [AW-1:0]          mark_wa;
  logic [1:0]             mark_wd;

  logic [1:0]             req_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [31:0]            h_r;
  logic [DW-1:0]          cap_r;
  logic [AW-1:0]          idx_r, idx_nxt;
  logic [DW-1:0]          cnt_r;
  logic                   seen_del_r, hit_r, empty_r;
  logic [AW-1:0]          del_idx_r, stop_idx_r;
  logic [1:0]             rmark_r;
  logic [KEY_WIDTH-1:0]   rkey_r;
  logic [VALUE_WIDTH-1:0] rval_r;
  logic [10:0]            occ_r;
  logic                   div_done;
  logic [DW-1:0]          rem;
  logic [31:0]            mag;
  logic [DW-1:0]          home;
  logic [1:0]             m;
  logic [DW-1:0]          idx_inc;
  logic                   found_w, ins_w, full_w;
  logic [AW-1:0]          dst;
  logic [DW-1:0]          cap_w;

  always_comb begin
    cap_w = DW'(cap_reg);
    if (cap_w == '0) cap_w = DW'(1);
    if (cap_w > DW'(TABLE_DEPTH)) cap_w = DW'(TABLE_DEPTH);
  end

  assign mag = h_r[31] ? (~h_r + 32'd1) : h_r;

  oaht_div #(.NW(32), .DW(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(mag),
    .den(cap_r), .done(div_done), .rem(rem)
  );

  always_comb begin
    if (h_r[31] && rem != '0) home = cap_r - rem;
    else home = rem;
  end

  assign m = rmark_r;
  assign idx_inc = DW'(idx_r) + DW'(1);

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.home) idx_nxt = AW'(home);
    else if (cmd.eval) idx_nxt = (idx_inc == cap_r) ? '0 : AW'(idx_inc);
  end

  assign sts.clearing = clr_r;
  assign sts.div_done = div_done;
  assign sts.stop = cmd.eval && (m == MARK_EMPTY ||
                    (m == MARK_OCCUPIED && rkey_r == key_r));
  assign sts.exhausted = (cnt_r == cap_r);

  always_comb begin
    found_w = 1'b0;
    ins_w = 1'b0;
    full_w = 1'b0;
    dst = seen_del_r ? del_idx_r : stop_idx_r;
    unique case (req_r)
      REQ_LOOKUP, REQ_REMOVE: found_w = hit_r;
      REQ_INSERT: begin
        found_w = hit_r;
        ins_w = !hit_r && (empty_r || seen_del_r);
        full_w = !hit_r && !empty_r && !seen_del_r;
      end
      default: ;
    endcase
  end

  // single mark write port: clearing pass, insert or remove
  always_comb begin
    mark_we = 1'b0;
    mark_wa = dst;
    mark_wd = MARK_OCCUPIED;
    if (clr_r) begin
      mark_we = 1'b1;
      mark_wa = clr_idx_r;
      mark_wd = MARK_EMPTY;
    end else if (cmd.commit && ins_w) begin
      mark_we = 1'b1;
    end else if (cmd.commit && req_r == REQ_REMOVE && hit_r) begin
      mark_we = 1'b1;
      mark_wa = stop_idx_r;
      mark_wd = MARK_DELETED;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type;
      key_r <= in_key;
      val_r <= in_value;
      cap_r <= cap_w;
    end
    if (cmd.hash) h_r <= 32'(key_r) * 32'(HashMult);
    idx_r <= idx_nxt;
    if (cmd.rd) begin
      rmark_r <= mark_mem[idx_r];
      rkey_r <= key_mem[idx_r];
      rval_r <= val_mem[idx_r];
    end
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    if (cmd.commit) begin
      if (ins_w) begin
        key_mem[dst] <= key_r;
        val_mem[dst] <= val_r;
      end else if (req_r == REQ_INSERT && hit_r) begin
        val_mem[stop_idx_r] <= val_r;
      end
      out_value_out <= (req_r == REQ_LOOKUP && hit_r) ? 32'(rval_r) : 32'd0;
      out_found <= found_w;
      out_inserted_new <= ins_w;
      out_table_full <= full_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= 1'b1;
      clr_idx_r <= '0;
      occ_r <= '0;
      cnt_r <= '0;
      seen_del_r <= 1'b0;
      hit_r <= 1'b0;
      empty_r <= 1'b0;
      out_entry_total <= '0;
    end else begin
      if (clr_r) begin
        clr_idx_r <= clr_idx_r + AW'(1);
        if (clr_idx_r == AW'(TABLE_DEPTH - 1)) clr_r <= 1'b0;
      end
      if (cmd.home) begin
        cnt_r <= '0;
        seen_del_r <= 1'b0;
        hit_r <= 1'b0;
        empty_r <= 1'b0;
      end else if (cmd.eval) begin
        cnt_r <= cnt_r + DW'(1);
        if (m == MARK_EMPTY) begin
          empty_r <= 1'b1;
          stop_idx_r <= idx_r;
        end else if (m == MARK_OCCUPIED) begin
          if (rkey_r == key_r) begin
            hit_r <= 1'b1;
            stop_idx_r <= idx_r;
          end
        end else if (!seen_del_r) begin
          seen_del_r <= 1'b1;
          del_idx_r <= idx_r;
        end
      end
      if (cmd.commit) begin
        if (ins_w) begin
          occ_r <= occ_r + 11'd1;
          out_entry_total <= occ_r + 11'd1;
        end else if (req_r == REQ_REMOVE && hit_r && occ_r != '0) begin
          occ_r <= occ_r - 11'd1;
          out_entry_total <= occ_r - 11'd1;
        end else begin
          out_entry_total <= occ_r;
        end
      end
    end
  end

endmodule

// ----- rtl/core/oaht_ctrl.sv -----
module oaht_ctrl
  import oaht_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  logic    req_none,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HASH = 3'd1;
  localparam logic [2:0] S_DIVS = 3'd2;
  localparam logic [2:0] S_DIVW = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_EVAL = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;
  logic       acc;

  assign in_stall = sts.clearing || (state_r != S_IDLE) || (ov_r && out_stall);
  assign acc = in_valid && !in_stall;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt = ov_r && out_stall;
    cmd = '0;
    unique case (state_r)
      S_IDLE: if (acc) begin
        cmd.load = 1'b1;
        state_nxt = S_HASH;
      end
      S_HASH: begin
        cmd.hash = 1'b1;
        state_nxt = req_none ? S_DONE : S_DIVS;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt = S_DIVW;
      end
      S_DIVW: if (sts.div_done) begin
        cmd.home = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        if (sts.exhausted) state_nxt = S_DONE;
        else begin
          cmd.rd = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        state_nxt = sts.stop ? S_DONE : S_RD;
      end
      S_DONE: if (!(ov_r && out_stall)) begin
        cmd.commit = 1'b1;
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end

endmodule

// ----- rtl/core/open_addressing_hash_table.sv -----
// Hash map engine, linear probing with deleted markers. One word at a time:
// each lookup, insert or remove runs the 32-step remainder unit once and
// then probes 1 to capacity slots, with one read of the single-port slot
// memory per probe. After reset the slot marks are cleared slot by slot,
// with in_stall held high meanwhile. The user must write the capacity only
// while idle; the block itself does not enforce this.
module open_addressing_hash_table
  import oaht_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WIDTH = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_req_type,
  input  logic signed [31:0]     in_key,
  input  logic signed [31:0]     in_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_found,
  output logic signed [31:0]     out_value_out,
  output logic                   out_inserted_new,
  output logic                   out_table_full,
  output logic [10:0]            out_entry_total,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [1:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  dp_cmd_t    cmd;
  dp_sts_t    sts;
  logic [10:0] cap_r;
  logic [1:0] req_r;

  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == 2'd0) ? {21'd0, cap_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= 11'd1024;
    else if (psel && penable && pwrite && paddr == 2'd0) cap_r <= pwdata[10:0];
  end

  always_ff @(posedge clk) if (cmd.load) req_r <= in_req_type;

  oaht_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .req_none(req_r == REQ_NONE), .sts(sts), .cmd(cmd)
  );

  oaht_dp #(
    .TABLE_DEPTH(TABLE_DEPTH), .KEY_WIDTH(KEY_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .cap_reg(cap_r),
    .in_req_type(in_req_type), .in_key(KEY_WIDTH'(in_key)),
    .in_value(VALUE_WIDTH'(in_value)),
    .out_found(out_found), .out_value_out(out_value_out),
    .out_inserted_new(out_inserted_new), .out_table_full(out_table_full),
    .out_entry_total(out_entry_total)
  );

endmodule

// ----- rtl/core/oaht_checker.sv -----
module oaht_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_found,
  input logic        out_inserted_new,
  input logic        out_table_full,
  input logic [10:0] out_entry_total
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_entry_total))
    else $error("result word dropped while stalled");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_found, out_inserted_new, out_table_full}) <= 1)
    else $error("conflicting result flags");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while busy");

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_total <= 11'd1024)
    else $error("entry total out of range");

endmodule

bind open_addressing_hash_table oaht_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_found(out_found),
  .out_inserted_new(out_inserted_new), .out_table_full(out_table_full),
  .out_entry_total(out_entry_total)
);
